[rtl/core/acss_pkg.sv]
package acss_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 10;
  localparam int SETTLE_W     = 10;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10);

  typedef enum logic [2:0] {
    PH_SELECT = 3'd0,
    PH_SETTLE = 3'd1,
    PH_START  = 3'd2,
    PH_WAIT   = 3'd3,
    PH_FINISH = 3'd4
  } phase_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_READ = 1'b1
  } req_t;

  typedef struct packed {
    req_t                req_type;
    logic                conv_done;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [CH_W-1:0]     read_channel;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          phase;
    logic [CH_W-1:0]     mux_channel;
    logic                start_conversion;
    logic                sample_stored;
    logic                scan_ready;
    logic [SAMPLE_W-1:0] read_value;
  } out_item_t;

endpackage

[rtl/core/acss_core.sv]
module acss_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [9:0]          cfg_wr_data,
  input  logic                item_en,
  input  acss_pkg::in_item_t  item,
  output acss_pkg::out_item_t res
);
  import acss_pkg::*;

  logic [SETTLE_W-1:0] settle_ticks_r;
  phase_t              phase_r, phase_nxt;
  logic [CH_W-1:0]     channel_r, channel_nxt;
  logic [CH_W-1:0]     mux_r, mux_nxt;
  logic [SETTLE_W-1:0] settle_cnt_r, settle_cnt_nxt;
  logic                ready_r, ready_nxt;
  logic [SAMPLE_W-1:0] store_r [NUM_CHANNELS];
  logic                store_we;
  logic                start_pulse;
  logic [SETTLE_W-1:0] settle_dec;

  assign settle_dec = (settle_cnt_r != '0) ? settle_cnt_r - 1'b1 : settle_cnt_r;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    channel_nxt    = channel_r;
    mux_nxt        = mux_r;
    settle_cnt_nxt = settle_cnt_r;
    ready_nxt      = ready_r;
    if (item.req_type == REQ_TICK) begin
      case (phase_r)
        PH_SETTLE: begin
          settle_cnt_nxt = settle_dec;
          if (settle_dec == '0) begin
            phase_nxt = PH_START;
          end
        end
        PH_START: begin
          phase_nxt = PH_WAIT;
        end
        PH_WAIT: begin
          if (item.conv_done) begin
            phase_nxt = PH_FINISH;
          end
        end
        PH_FINISH: begin
          if ({1'b0, channel_r} >= (CH_W+1)'(NUM_CHANNELS - 1)) begin
            channel_nxt = '0;
            ready_nxt   = 1'b1;
          end else begin
            channel_nxt = channel_r + 1'b1;
          end
          phase_nxt = PH_SELECT;
        end
        default: begin
          mux_nxt        = channel_r;
          settle_cnt_nxt = (settle_ticks_r == '0) ? SETTLE_W'(1) : settle_ticks_r;
          phase_nxt      = PH_SETTLE;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    start_pulse = 1'b0;
    store_we    = 1'b0;
    if (item.req_type == REQ_TICK) begin
      case (phase_r)
        PH_START: start_pulse = 1'b1;
        PH_WAIT:  store_we    = item.conv_done;
        default: begin
          start_pulse = 1'b0;
          store_we    = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res.phase            = phase_nxt;
    res.mux_channel      = mux_nxt;
    res.start_conversion = start_pulse;
    res.sample_stored    = store_we;
    res.scan_ready       = ready_nxt;
    res.read_value       = '0;
    if (item.req_type == REQ_READ &&
        {1'b0, item.read_channel} < (CH_W+1)'(NUM_CHANNELS)) begin
      res.read_value = store_r[item.read_channel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
      phase_r        <= PH_SELECT;
      channel_r      <= '0;
      mux_r          <= '0;
      settle_cnt_r   <= '0;
      ready_r        <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        settle_ticks_r <= cfg_wr_data;
      end
      if (item_en) begin
        phase_r      <= phase_nxt;
        channel_r    <= channel_nxt;
        mux_r        <= mux_nxt;
        settle_cnt_r <= settle_cnt_nxt;
        ready_r      <= ready_nxt;
        if (store_we) begin
          store_r[channel_r] <= item.adc_sample;
        end
      end
    end
  end

endmodule

[rtl/core/adc_channel_scan_sequencer.sv]
// adc channel scan sequencer
// the result of each input transfer is registered and shown on out_tdata in the next cycle
// throughput: one item per cycle while out_tready is high; the single result register sets the pace
// reset (rst_n low, synchronous): select phase, channel 0, samples and
// scan_ready cleared, settle_ticks back to 10, result register empty
module adc_channel_scan_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // conv_done, adc_sample[9:0], read_channel[2:0], zero pad
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // phase[2:0], mux_channel[2:0], start_conversion,
                                  // sample_stored, scan_ready, read_value[9:0], zero pad
);
  import acss_pkg::*;

  in_item_t  item;
  out_item_t res;
  out_item_t res_r;
  logic      out_valid_r;
  logic      in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign item.req_type     = req_t'(in_tuser);
  assign item.conv_done    = in_tdata[0];
  assign item.adc_sample   = in_tdata[10:1];
  assign item.read_channel = in_tdata[13:11];

  acss_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_en     (in_xfer),
    .item        (item),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.read_value, res_r.scan_ready, res_r.sample_stored,
                       res_r.start_conversion, res_r.mux_channel, res_r.phase};

endmodule
